FILE: design/pbr_pkg.sv
// Shared types, constants and sequencer program for the polynomial bisection root finder.
package pbr_pkg;

   localparam int DATA_W    = 32;
   localparam int ACC_W     = 64;
   localparam int ORDER_W   = 3;
   localparam int CSR_IDX_W = 8;
   localparam int PC_W      = 4;

   // Register indexes on the csr port
   localparam logic [CSR_IDX_W-1:0] REG_POLY_ORDER = 8'd0;
   localparam logic [CSR_IDX_W-1:0] REG_COEF_0     = 8'd1;

   typedef enum logic [1:0] {
      OUT_WIDTH     = 2'd0,
      OUT_NEAR      = 2'd1,
      OUT_ENDPOINT  = 2'd2,
      OUT_NO_CHANGE = 2'd3
   } outcome_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] lower_bound;
      logic signed [DATA_W-1:0] upper_bound;
   } req_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] root;
      outcome_type              outcome;
   } rsp_type;

   typedef logic [PC_W-1:0] pc_type;

   // Datapath operation of one control word
   typedef enum logic [3:0] {
      OP_NOP,
      OP_LOAD,
      OP_SAVE_FA,
      OP_ENDS,
      OP_MIDPOINT,
      OP_UPDATE,
      OP_EMIT,
      OP_INIT,
      OP_MAG,
      OP_MUL_LO,
      OP_MUL_HI,
      OP_SCALE,
      OP_ADD
   } op_type;

   // Sequencing of one control word
   typedef enum logic [3:0] {
      C_NEXT,
      C_JUMP,
      C_CALL,
      C_NO_REQ,
      C_ENDS,
      C_NARROW,
      C_NEAR,
      C_OUT_BUSY,
      C_RET_IF_ZERO,
      C_LOOP_ELSE_RET
   } cond_type;

   typedef struct packed {
      op_type   op;
      cond_type cond;
      pc_type   target;
   } uword_type;

   localparam pc_type PC_IDLE   = 4'd0;
   localparam pc_type PC_LOOP   = 4'd4;
   localparam pc_type PC_FINISH = 4'd8;
   localparam pc_type PC_EVAL   = 4'd10;
   localparam pc_type PC_E_LOOP = 4'd11;

   // Control store
   function automatic uword_type urom(input pc_type pc);
      uword_type w;
      case (pc)
         4'd0:    w = '{OP_LOAD,     C_NO_REQ,        PC_IDLE};   // wait for a bracket
         4'd1:    w = '{OP_NOP,      C_CALL,          PC_EVAL};   // p(lower)
         4'd2:    w = '{OP_SAVE_FA,  C_CALL,          PC_EVAL};   // p(upper)
         4'd3:    w = '{OP_ENDS,     C_ENDS,          PC_FINISH};
         4'd4:    w = '{OP_MIDPOINT, C_NARROW,        PC_FINISH}; // halving loop head
         4'd5:    w = '{OP_NOP,      C_CALL,          PC_EVAL};   // p(mid)
         4'd6:    w = '{OP_UPDATE,   C_NEAR,          PC_FINISH};
         4'd7:    w = '{OP_NOP,      C_JUMP,          PC_LOOP};
         4'd8:    w = '{OP_EMIT,     C_OUT_BUSY,      PC_FINISH};
         4'd9:    w = '{OP_NOP,      C_JUMP,          PC_IDLE};
         4'd10:   w = '{OP_INIT,     C_RET_IF_ZERO,   PC_IDLE};   // Horner entry
         4'd11:   w = '{OP_MAG,      C_NEXT,          PC_IDLE};
         4'd12:   w = '{OP_MUL_LO,   C_NEXT,          PC_IDLE};
         4'd13:   w = '{OP_MUL_HI,   C_NEXT,          PC_IDLE};
         4'd14:   w = '{OP_SCALE,    C_NEXT,          PC_IDLE};
         4'd15:   w = '{OP_ADD,      C_LOOP_ELSE_RET, PC_E_LOOP};
         default: w = '{OP_NOP,      C_JUMP,          PC_IDLE};
      endcase
      return w;
   endfunction

endpackage

FILE: design/polynomial_bisection_root.sv
// Bisection root finder for a polynomial of up to MAX_ORDER, run by a microcoded sequencer.
// Each Horner step of an evaluation runs the magnitude, low and high multiply, scale and add
//   steps; a bracket evaluates both ends and, unless an endpoint decides, each midpoint until
//   the width or value test exits. The single shared 32x32 multiplier is used twice per Horner step.
// Throughput: one bracket at a time; the next beat is taken once the result is registered,
//   even while that result still waits on rsp_stall.
// Reset: synchronous, active high; clears the sequencer, output valid and all csr registers.
module polynomial_bisection_root #(
   parameter int MAX_ORDER     = 6,
   parameter int FRACTION_BITS = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  pbr_pkg::req_type                req_data,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output pbr_pkg::rsp_type                rsp_data,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [pbr_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [pbr_pkg::DATA_W-1:0]      csr_wdata
);
   import pbr_pkg::*;

   localparam int CIDX_W = $clog2(MAX_ORDER + 1);

   // Tolerances, rounded to the nearest step of the fixed-point grid
   localparam logic [ACC_W-1:0] WIDTH_TOL =
      ((64'd1 << FRACTION_BITS) + 64'd500) / 64'd1000;
   localparam logic [ACC_W-1:0] VALUE_TOL =
      ((64'd1 << (2 * FRACTION_BITS)) + 64'd500000) / 64'd1000000;
   localparam logic signed [DATA_W:0] WIDTH_TOL_S = {1'b0, WIDTH_TOL[DATA_W-1:0]};

   localparam logic [ACC_W-1:0] POS_LIMIT = {1'b0, {(ACC_W-1){1'b1}}};
   localparam logic [ACC_W-1:0] NEG_LIMIT = {1'b1, {(ACC_W-1){1'b0}}};

   // Sequencer
   pc_type    pc_ff, pc_in;
   pc_type    ret_ff, ret_in;
   uword_type uw;

   // Configuration
   logic [ORDER_W-1:0]       order_ff;
   logic signed [DATA_W-1:0] coef_ff [MAX_ORDER+1];

   // Datapath
   logic signed [DATA_W-1:0] a_ff, a_in;
   logic signed [DATA_W-1:0] b_ff, b_in;
   logic signed [DATA_W-1:0] x_ff, x_in;
   logic signed [ACC_W-1:0]  fa_ff, fa_in;
   logic signed [ACC_W-1:0]  acc_ff, acc_in;
   logic [ACC_W-1:0]         mag_ff, mag_in;
   logic [DATA_W-1:0]        magx_ff, magx_in;
   logic                     neg_ff, neg_in;
   logic [ACC_W-1:0]         plo_ff, plo_in;
   logic [ACC_W-1:0]         phi_ff, phi_in;
   logic [CIDX_W-1:0]        idx_ff, idx_in;
   logic signed [DATA_W-1:0] res_root_ff, res_root_in;
   outcome_type              res_outcome_ff, res_outcome_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   rsp_type                  rsp_data_ff, rsp_data_in;

   logic                     req_accept;
   logic                     out_free;
   logic [CIDX_W-1:0]        order_n;
   logic [CIDX_W-1:0]        rd_idx;
   logic signed [DATA_W-1:0] coef_rd;
   logic [ACC_W-1:0]         coef_q;
   logic [DATA_W:0]          sum_ab;
   logic signed [DATA_W:0]   width_ab;
   logic signed [DATA_W-1:0] mid;
   logic                     narrow;
   logic [ACC_W-1:0]         acc_mag;
   logic [DATA_W-1:0]        x_mag;
   logic [DATA_W-1:0]        mul_a;
   logic [ACC_W-1:0]         mul_p;
   logic                     hi_over;
   logic [ACC_W-1:0]         s_val;
   logic [ACC_W-1:0]         t_val;
   logic [ACC_W:0]           st_sum;
   logic [ACC_W-1:0]         limit;
   logic [ACC_W-1:0]         scaled_mag;
   logic [ACC_W-1:0]         scaled;
   logic [ACC_W:0]           add_sum;
   logic [ACC_W-1:0]         added;
   logic                     fa_zero;
   logic                     fb_zero;
   logic                     same_sign;
   logic                     ends_decided;
   logic                     near;

   // Handshakes: take a bracket only while parked at the idle step and out of reset
   assign uw         = urom(pc_ff);
   assign req_stall  = reset || (pc_ff != PC_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_data_ff;
   assign csr_ready  = !reset;

   // Orders above MAX_ORDER behave as MAX_ORDER
   always_comb begin
      if (order_ff > ORDER_W'(MAX_ORDER)) begin
         order_n = CIDX_W'(MAX_ORDER);
      end else begin
         order_n = CIDX_W'(order_ff);
      end
   end

   // One coefficient read port: the top term at entry, the running index otherwise
   assign rd_idx  = (uw.op == OP_INIT) ? order_n : idx_ff;
   assign coef_rd = coef_ff[rd_idx];
   assign coef_q  = {{(ACC_W-DATA_W){coef_rd[DATA_W-1]}}, coef_rd} << FRACTION_BITS;

   // Floored midpoint and bracket width, exact in one extra bit
   assign sum_ab   = {a_ff[DATA_W-1], a_ff} + {b_ff[DATA_W-1], b_ff};
   assign mid      = sum_ab[DATA_W:1];
   assign width_ab = {b_ff[DATA_W-1], b_ff} - {a_ff[DATA_W-1], a_ff};
   assign narrow   = width_ab < WIDTH_TOL_S;

   // Magnitudes; the most negative accumulator maps to 2^63, which still fits
   assign acc_mag = acc_ff[ACC_W-1] ? (~acc_ff + 64'd1) : acc_ff;
   assign x_mag   = x_ff[DATA_W-1] ? (~x_ff + 32'd1) : x_ff;

   // Shared multiplier: low half of |acc| first, high half next
   assign mul_a = (uw.op == OP_MUL_HI) ? mag_ff[ACC_W-1:DATA_W] : mag_ff[DATA_W-1:0];
   assign mul_p = mul_a * magx_ff;

   // Recombine partial products, drop the fraction, clamp to the signed range
   always_comb begin
      hi_over = (phi_ff >> (DATA_W + FRACTION_BITS)) != '0;
      s_val   = phi_ff << (DATA_W - FRACTION_BITS);
      t_val   = plo_ff >> FRACTION_BITS;
      st_sum  = {1'b0, s_val} + {1'b0, t_val};
      limit   = neg_ff ? NEG_LIMIT : POS_LIMIT;
      if (hi_over || st_sum[ACC_W] || (st_sum[ACC_W-1:0] > limit)) begin
         scaled_mag = limit;
      end else begin
         scaled_mag = st_sum[ACC_W-1:0];
      end
      scaled = neg_ff ? (~scaled_mag + 64'd1) : scaled_mag;
   end

   // Saturating add of the next coefficient
   always_comb begin
      add_sum = {acc_ff[ACC_W-1], acc_ff} + {coef_q[ACC_W-1], coef_q};
      if (add_sum[ACC_W] != add_sum[ACC_W-1]) begin
         added = add_sum[ACC_W] ? NEG_LIMIT : POS_LIMIT;
      end else begin
         added = add_sum[ACC_W-1:0];
      end
   end

   // Decisions; acc holds p(upper) at the endpoint test and p(mid) in the loop
   assign fa_zero      = (fa_ff == '0);
   assign fb_zero      = (acc_ff == '0);
   assign same_sign    = !fa_zero && !fb_zero && (fa_ff[ACC_W-1] == acc_ff[ACC_W-1]);
   assign ends_decided = same_sign || fa_zero || fb_zero;
   assign near         = (acc_mag <= VALUE_TOL);

   // Step counter: conditional jumps, one level of call and return for Horner
   always_comb begin
      pc_in  = pc_ff + PC_W'(1);
      ret_in = ret_ff;
      case (uw.cond)
         C_NEXT:     pc_in = pc_ff + PC_W'(1);
         C_JUMP:     pc_in = uw.target;
         C_CALL: begin
            pc_in  = uw.target;
            ret_in = pc_ff + PC_W'(1);
         end
         C_NO_REQ:   if (!req_accept) pc_in = uw.target;
         C_ENDS:     if (ends_decided) pc_in = uw.target;
         C_NARROW:   if (narrow) pc_in = uw.target;
         C_NEAR:     if (near) pc_in = uw.target;
         C_OUT_BUSY: if (!out_free) pc_in = uw.target;
         C_RET_IF_ZERO: begin
            if (order_n == '0) pc_in = ret_ff;
         end
         C_LOOP_ELSE_RET: begin
            pc_in = (idx_ff != '0) ? uw.target : ret_ff;
         end
         default:    pc_in = PC_IDLE;
      endcase
   end

   // Datapath driven by the control word
   always_comb begin
      a_in           = a_ff;
      b_in           = b_ff;
      x_in           = x_ff;
      fa_in          = fa_ff;
      acc_in         = acc_ff;
      mag_in         = mag_ff;
      magx_in        = magx_ff;
      neg_in         = neg_ff;
      plo_in         = plo_ff;
      phi_in         = phi_ff;
      idx_in         = idx_ff;
      res_root_in    = res_root_ff;
      res_outcome_in = res_outcome_ff;
      rsp_data_in    = rsp_data_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      case (uw.op)
         OP_NOP: ;
         OP_LOAD: begin
            if (req_accept) begin
               a_in = req_data.lower_bound;
               b_in = req_data.upper_bound;
               x_in = req_data.lower_bound;
            end
         end
         OP_SAVE_FA: begin
            fa_in = acc_ff;
            x_in  = b_ff;
         end
         OP_ENDS: begin
            // Both ends zero returns the lower end
            if (same_sign) begin
               res_root_in    = '0;
               res_outcome_in = OUT_NO_CHANGE;
            end else if (fa_zero) begin
               res_root_in    = a_ff;
               res_outcome_in = OUT_ENDPOINT;
            end else begin
               res_root_in    = b_ff;
               res_outcome_in = OUT_ENDPOINT;
            end
         end
         OP_MIDPOINT: begin
            x_in           = mid;
            res_root_in    = mid;
            res_outcome_in = OUT_WIDTH;
         end
         OP_UPDATE: begin
            if (near) begin
               res_outcome_in = OUT_NEAR;
            end else if (fa_ff[ACC_W-1] != acc_ff[ACC_W-1]) begin
               b_in = x_ff;
            end else begin
               a_in  = x_ff;
               fa_in = acc_ff;
            end
         end
         OP_EMIT: begin
            if (out_free) begin
               rsp_data_in.root    = res_root_ff;
               rsp_data_in.outcome = res_outcome_ff;
               rsp_valid_in        = 1'b1;
            end
         end
         OP_INIT: begin
            acc_in = coef_q;
            idx_in = order_n;
         end
         OP_MAG: begin
            mag_in  = acc_mag;
            magx_in = x_mag;
            neg_in  = acc_ff[ACC_W-1] != x_ff[DATA_W-1];
         end
         OP_MUL_LO: plo_in = mul_p;
         OP_MUL_HI: phi_in = mul_p;
         OP_SCALE: begin
            acc_in = scaled;
            idx_in = idx_ff - CIDX_W'(1);
         end
         OP_ADD:    acc_in = added;
         default: ;
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff        <= PC_IDLE;
         ret_ff       <= PC_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         pc_ff        <= pc_in;
         ret_ff       <= ret_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      a_ff           <= a_in;
      b_ff           <= b_in;
      x_ff           <= x_in;
      fa_ff          <= fa_in;
      acc_ff         <= acc_in;
      mag_ff         <= mag_in;
      magx_ff        <= magx_in;
      neg_ff         <= neg_in;
      plo_ff         <= plo_in;
      phi_ff         <= phi_in;
      idx_ff         <= idx_in;
      res_root_ff    <= res_root_in;
      res_outcome_ff <= res_outcome_in;
      rsp_data_ff    <= rsp_data_in;
   end

   // Csr writes; coefficients above MAX_ORDER are never read, so drop them
   always_ff @(posedge clock) begin
      if (reset) begin
         order_ff <= '0;
         for (int i = 0; i <= MAX_ORDER; i++) begin
            coef_ff[i] <= '0;
         end
      end else if (csr_valid && csr_ready) begin
         if (csr_index == REG_POLY_ORDER) begin
            order_ff <= csr_wdata[ORDER_W-1:0];
         end
         for (int i = 0; i <= MAX_ORDER; i++) begin
            if (csr_index == (REG_COEF_0 + CSR_IDX_W'(i))) begin
               coef_ff[i] <= csr_wdata;
            end
         end
      end
   end

endmodule

FILE: design/pbr_checker.sv
// Port-level assertions for the polynomial bisection root finder, bound to the top level.
module pbr_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_stall,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input pbr_pkg::rsp_type rsp_data
);
   import pbr_pkg::*;

   // Hold a stalled result beat
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result beat changed");

   // Go busy right after taking a bracket
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("input not stalled after accepted beat");

   // A result appears only out of a busy sequencer
   a_rsp_from_busy: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("result raised while idle");

   // No sign change reports a zero root
   a_no_change_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.outcome == OUT_NO_CHANGE) |-> (rsp_data.root == '0))
      else $error("no-root result with nonzero root");

endmodule

bind polynomial_bisection_root pbr_checker u_pbr_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
